// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion helper macros
// clocked concurrent checks that vanish when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk_sig, rst_n_sig, cond) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop)
`define ASSERT_NEVER(label, clk_sig, rst_n_sig, cond)

`endif

`endif

// ===== src/hfc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hfc_pkg
// types and constants for the binary32 / binary16 converter
// ---------------------------------------------------------------------------
package hfc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned HALF_W = 16;
	localparam int unsigned SHIFT_W = 7;  // holds 113 - exponent
	localparam int unsigned LZ_W = 4;     // subnormal normalize shift, 1..10

	// largest single exponent that lands in the half subnormal range
	localparam logic [7:0] SUB_EXP_MAX = 8'd112;
	localparam logic [7:0] SUB_EXP_REF = 8'd113;
	localparam logic [SHIFT_W-1:0] SHIFT_ZERO = 7'd32;
	// rebias of a normal half exponent into single format
	localparam logic [30:0] REBIAS_ADD = 31'h3800_0000;
	localparam logic [14:0] HALF_SUB_MAX = 15'h03ff;

	typedef enum logic {
		ACT_S2H = 1'b0,
		ACT_H2S = 1'b1
	} act_t;

endpackage

// ===== src/half_float_converter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// half_float_converter_core
// binary32 <-> binary16 bit pattern converter, three stage pipeline
// ---------------------------------------------------------------------------
//
// channel   handshake              payload
// req       req_valid/req_ready    action, operand_bits
// rsp       rsp_valid/rsp_ready    result_bits
//
// one word per cycle sustained while rsp_ready stays high; an accepted word is
// registered in stage 1, stage 2 and stage 3 before rsp_valid rises.
// stage 1 decodes (subnormal shift count, half leading-one search), stage 2
// does the shift / rebias, stage 3 is the output register.
// each stage advances when its successor is empty or moving, so a stall on
// rsp backs up one stage at a time and no word is dropped or repeated.
// reset clears the valid bits only.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module half_float_converter_core
	import hfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              action,
	input  logic [WORD_W-1:0] operand_bits,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [WORD_W-1:0] result_bits
);

	logic v_s1, v_s2, v_s3;
	logic ready_s1, ready_s2, ready_s3;

	act_t              act_s1, act_s2, act_s3;
	logic [WORD_W-1:0] op_s1;
	logic              sub_s1;
	logic [SHIFT_W-1:0] sh_s1;
	logic [LZ_W-1:0]   lz_s1;
	logic [WORD_W-1:0] res_s2, res_s3;

	logic               sub_d;
	logic [SHIFT_W-1:0] sh_d;
	logic [LZ_W-1:0]    lz_d;
	logic [WORD_W-1:0]  res_d;

	assign ready_s3 = !v_s3 || rsp_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign req_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= req_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
		end
	end

	// stage 1 decode
	always_comb begin
		sub_d = (operand_bits[30:23] <= SUB_EXP_MAX);
		sh_d  = SHIFT_W'(SUB_EXP_REF - operand_bits[30:23]);
		// leading one of a subnormal half mantissa; highest set bit wins
		lz_d = '0;
		for (int i = 0; i < 10; i++) begin
			if (operand_bits[i]) lz_d = LZ_W'(10 - i);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			act_s1 <= act_t'(action);
			op_s1  <= operand_bits;
			sub_s1 <= sub_d;
			sh_s1  <= sh_d;
			lz_s1  <= lz_d;
		end
	end

	// stage 2 shift and rebias
	always_comb begin
		logic [23:0] frac_sh;
		logic [14:0] half_mag;
		logic [14:0] em;
		logic [10:0] norm;
		logic [7:0]  sub_exp;
		logic [30:0] rebias;

		frac_sh  = {1'b1, op_s1[22:0]} >> sh_s1[4:0];
		em       = op_s1[14:0];
		norm     = {1'b0, em[9:0]} << lz_s1;
		sub_exp  = SUB_EXP_REF - {4'b0, lz_s1};
		rebias   = {3'b0, em, 13'b0} + REBIAS_ADD;
		half_mag = '0;
		res_d    = '0;

		unique case (act_s1)
			ACT_S2H: begin
				if (!sub_s1) begin
					// exponent wraps: keep bit 7 and the low four bits
					half_mag = {op_s1[30], op_s1[26:23], op_s1[22:13]};
				end else if (sh_s1 >= SHIFT_ZERO) begin
					half_mag = '0;
				end else begin
					half_mag = {4'b0, frac_sh[23:13]};
				end
				res_d = {{(WORD_W-HALF_W){1'b0}}, op_s1[31], half_mag};
			end
			ACT_H2S: begin
				if (em > HALF_SUB_MAX) begin
					res_d = {op_s1[15], rebias};
				end else if (em != '0) begin
					res_d = {op_s1[15], sub_exp, norm[9:0], 13'b0};
				end else begin
					res_d = {op_s1[15], 31'b0};
				end
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			act_s2 <= act_s1;
			res_s2 <= res_d;
		end
		if (ready_s3) begin
			act_s3 <= act_s2;
			res_s3 <= res_s2;
		end
	end

	assign rsp_valid   = v_s3;
	assign result_bits = res_s3;

	`ASSERT_CLK(a_half_upper_zero, clk, arst_n, (v_s3 && act_s3 == ACT_S2H) |-> (res_s3[31:16] == '0))
	`ASSERT_CLK(a_s1_drains_on_accept, clk, arst_n, (req_ready && v_s1) |-> ready_s2)
	`ASSERT_CLK(a_s2_holds_on_stall, clk, arst_n, (v_s2 && !ready_s3) |=> (v_s2 && $stable(res_s2)))
	`ASSERT_NEVER(a_bubble_blocks, clk, arst_n, !req_ready && !(v_s1 && v_s2 && v_s3))

endmodule

// ===== dv/tb_half_float_converter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_half_float_converter_core
// checks single/half bit conversion words against an in-bench predictor,
// starting with a directed table and then random words, with random idling
// on both channels
// ---------------------------------------------------------------------------
module tb_half_float_converter_core;
	import hfc_pkg::*;

	localparam int N_DIRECTED = 23;
	localparam int N_RANDOM = 1500;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 36;

	typedef struct packed {
		act_t        act;
		logic [31:0] operand;
		logic        typed;
		logic [31:0] result;
	} stim_row_t;

	// typed results only where the answer is obvious, the rest go to the predictor
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{ACT_S2H, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{ACT_S2H, 32'h8000_0000, 1'b1, 32'h0000_8000},
		'{ACT_S2H, 32'h3f80_0000, 1'b1, 32'h0000_3c00},
		'{ACT_S2H, 32'h477f_e000, 1'b1, 32'h0000_7bff},
		'{ACT_S2H, 32'h3880_0000, 1'b1, 32'h0000_0400},
		'{ACT_S2H, 32'h3800_0000, 1'b0, 32'h0},
		'{ACT_S2H, 32'hb87f_ffff, 1'b0, 32'h0},
		'{ACT_S2H, 32'h2880_0000, 1'b0, 32'h0},
		'{ACT_S2H, 32'h2900_0000, 1'b0, 32'h0},
		'{ACT_S2H, 32'h6400_0000, 1'b0, 32'h0},
		'{ACT_S2H, 32'h7f80_0000, 1'b0, 32'h0},
		'{ACT_S2H, 32'h7fff_ffff, 1'b0, 32'h0},
		'{ACT_S2H, 32'hffff_ffff, 1'b0, 32'h0},
		'{ACT_H2S, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{ACT_H2S, 32'h0000_8000, 1'b1, 32'h8000_0000},
		'{ACT_H2S, 32'h0000_0400, 1'b1, 32'h3880_0000},
		'{ACT_H2S, 32'h0000_3c00, 1'b1, 32'h3f80_0000},
		'{ACT_H2S, 32'habcd_3c00, 1'b1, 32'h3f80_0000},
		'{ACT_H2S, 32'h0000_0001, 1'b0, 32'h0},
		'{ACT_H2S, 32'h0000_83ff, 1'b0, 32'h0},
		'{ACT_H2S, 32'h0000_7c00, 1'b0, 32'h0},
		'{ACT_H2S, 32'h0000_7fff, 1'b0, 32'h0},
		'{ACT_H2S, 32'hffff_ffff, 1'b0, 32'h0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic        action = 1'b0;
	logic [31:0] operand_bits = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [31:0] result_bits;

	// typed answer travelling with the word on the req side
	logic        row_typed = 1'b0;
	logic [31:0] row_result = '0;

	logic [31:0] pending_results [$];
	logic [31:0] oldest_result;
	logic        calm = 1'b0;
	int          fail_count = 0;
	int          cycle_count = 0;

	half_float_converter_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.action      (action),
		.operand_bits(operand_bits),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.result_bits (result_bits)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] convert_bits(act_t act, logic [31:0] op);
		logic [7:0]  exp_s;
		logic [31:0] shift;
		logic [31:0] mag;
		logic [15:0] half;
		logic [14:0] em;
		logic [10:0] frac;
		logic [31:0] single;
		int          k;
		if (act == ACT_S2H) begin
			exp_s = op[30:23];
			if (exp_s <= 8'd112) begin
				shift = 32'd113 - {24'd0, exp_s};
				if (shift >= 32) begin
					half = '0;
				end else begin
					mag = {8'd0, 1'b1, op[22:0]};
					mag = (mag >> shift) >> 13;
					half = mag[15:0];
				end
			end else begin
				// exponent wraps: bit 7 plus the low four bits
				half = {2'b00, op[26:13]};
			end
			half[15:14] = half[15:14] | op[31:30];
			return {16'h0000, half};
		end
		em = op[14:0];
		single = {op[15], 31'd0};
		if (em > 15'h03ff) begin
			single = single | (({17'd0, em} << 13) + (32'd112 << 23));
		end else if (em != 15'd0) begin
			// normalize the subnormal
			frac = em[10:0];
			k = 0;
			while (frac[10] == 1'b0 && k < 11) begin
				frac = frac << 1;
				k++;
			end
			single = single | (32'(113 - k) << 23) | ({22'd0, frac[9:0]} << 13);
		end
		return single;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %08h want %08h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic drive_word(act_t act, logic [31:0] op, logic typed, logic [31:0] res);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		operand_bits <= op;
		row_typed <= typed;
		row_result <= res;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drive_random_word();
		act_t        act;
		logic [31:0] op;
		int          pick;
		act = act_t'($urandom_range(0, 1));
		op = $urandom;
		pick = $urandom_range(0, 9);
		if (act == ACT_S2H) begin
			case (pick)
				4, 5, 6: begin
					// around the subnormal boundary
					op[30:23] = 8'($urandom_range(100, 125));
				end
				7: begin
					// around the shift-to-zero boundary
					op[30:23] = 8'($urandom_range(75, 90));
				end
				8: begin
					op[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
				end
				default: begin
				end
			endcase
		end else begin
			case (pick)
				5, 6, 7: begin
					op[14:10] = 5'd0;
				end
				8: begin
					op[14:0] = 15'd0;
				end
				9: begin
					op[14:10] = 5'h1f;
				end
				default: begin
				end
			endcase
		end
		drive_word(act, op, 1'b0, 32'h0);
	endtask

	// receiver side
	always @(negedge clk) begin
		rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// both handshakes seen at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				pending_results.push_back(row_typed ? row_result :
					convert_bits(act_t'(action), operand_bits));
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("word with nothing pending", result_bits, 32'h0);
				end else begin
					oldest_result = pending_results.pop_front();
					if (result_bits !== oldest_result)
						report_mismatch("result_bits", result_bits, oldest_result);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < N_DIRECTED; i++)
			drive_word(directed_rows[i].act, directed_rows[i].operand,
				directed_rows[i].typed, directed_rows[i].result);
		for (int i = 0; i < N_RANDOM; i++) begin
			calm <= (i >= 500 && i < 800);
			drive_random_word();
		end
		req_valid <= 1'b0;
		calm <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== half_float_converter_core.f =====
+incdir+src
src/hfc_pkg.sv
src/half_float_converter_core.sv
dv/tb_half_float_converter_core.sv
